// ===== hdl/sorted_key_store_listing_assert.svh =====
// assertion helpers used by the datapath rtl
`ifndef SORTED_KEY_STORE_LISTING_ASSERT_SVH
`define SORTED_KEY_STORE_LISTING_ASSERT_SVH

// condition that must hold on every clock out of reset
`define SKS_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// same-cycle implication
`define SKS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== hdl/sks_pkg.sv =====
`timescale 1ns / 1ps
package sks_pkg;

   localparam int DEF_CAPACITY = 64;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_ASCEND = 2'd1;
   localparam logic [1:0] MODE_DESCEND = 2'd2;

   localparam logic [1:0] KIND_KEY = 2'd0;
   localparam logic [1:0] KIND_EMPTY = 2'd1;
   localparam logic [1:0] KIND_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] key;
   } req_type;

   typedef struct packed {
      logic signed [31:0] key_out;
      logic [1:0]         kind;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic       load;        // latch word, set pointer
      logic       rd;          // registered memory read
      logic       shift;       // move read entry up one slot
      logic       place;       // write key at pointer, count up
      logic       step;        // listing pointer advance
      logic       emit_key;
      logic       emit_status;
      logic [1:0] status_kind;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic full;
      logic gt;
      logic ptr_zero;
      logic list_done;
   } status_type;

endpackage

// ===== hdl/sks_datapath.sv =====
`timescale 1ns / 1ps
`include "sorted_key_store_listing_assert.svh"
module sks_datapath #(
   parameter int CAPACITY = sks_pkg::DEF_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   input  sks_pkg::req_type   req,
   input  sks_pkg::cmd_type   cmd,
   output sks_pkg::status_type status,
   output logic               rsp_valid,
   output sks_pkg::rsp_type   rsp
);
   import sks_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   logic signed [31:0] mem [CAPACITY];
   logic signed [31:0] rd_data_ff;
   logic signed [31:0] key_ff, key_in;
   logic [1:0]         mode_ff, mode_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [CW-1:0]      raddr;

   assign raddr = (mode_ff == MODE_INSERT) ? ptr_ff - CW'(1) : ptr_ff;

   always_comb begin
      key_in = key_ff;
      mode_in = mode_ff;
      count_in = count_ff;
      ptr_in = ptr_ff;
      if (cmd.load) begin
         key_in = req.key;
         mode_in = req.mode;
         if (req.mode == MODE_INSERT) begin
            ptr_in = count_ff;
         end else if (req.mode == MODE_ASCEND) begin
            ptr_in = '0;
         end else begin
            ptr_in = count_ff - CW'(1);
         end
      end
      if (cmd.shift) ptr_in = ptr_ff - CW'(1);
      if (cmd.place) count_in = count_ff + CW'(1);
      if (cmd.step) begin
         ptr_in = (mode_ff == MODE_ASCEND) ? ptr_ff + CW'(1) : ptr_ff - CW'(1);
      end
      rsp_valid_in = cmd.emit_key | cmd.emit_status;
      rsp_in = rsp_ff;
      if (cmd.emit_key) begin
         rsp_in.key_out = rd_data_ff;
         rsp_in.kind = KIND_KEY;
         rsp_in.last = status.list_done;
      end else if (cmd.emit_status) begin
         rsp_in.key_out = '0;
         rsp_in.kind = cmd.status_kind;
         rsp_in.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff <= key_in;
      mode_ff <= mode_in;
      ptr_ff <= ptr_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) rd_data_ff <= mem[raddr[AW-1:0]];
      if (cmd.shift) begin
         mem[ptr_ff[AW-1:0]] <= rd_data_ff;
      end else if (cmd.place) begin
         mem[ptr_ff[AW-1:0]] <= key_ff;
      end
   end

   always_comb begin
      status.count_zero = (count_ff == '0);
      status.full = (count_ff == CW'(CAPACITY));
      status.gt = (rd_data_ff > key_ff);
      status.ptr_zero = (ptr_ff == '0);
      status.list_done = (mode_ff == MODE_ASCEND) ? (ptr_ff == count_ff - CW'(1))
                                                  : (ptr_ff == '0);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   `SKS_ASSERT_ALWAYS(a_count_max, count_ff <= CW'(CAPACITY), "entry count past capacity")
   `SKS_ASSERT_IMPL(a_shift_ptr, cmd.shift, ptr_ff != '0, "shift at bottom of row")
   `SKS_ASSERT_IMPL(a_place_room, cmd.place, count_ff < CW'(CAPACITY), "place into full row")
   `SKS_ASSERT_IMPL(a_status_last, rsp_valid_ff && rsp_ff.kind != KIND_KEY, rsp_ff.last,
                    "status word without last mark")
endmodule

// ===== hdl/sks_control.sv =====
`timescale 1ns / 1ps
module sks_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  sks_pkg::req_type    req,
   input  sks_pkg::status_type status,
   output logic                busy,
   output sks_pkg::cmd_type    cmd
);
   import sks_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_INS_RD, ST_INS_CMP, ST_LST_RD, ST_LST_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req.mode)
                  MODE_INSERT: begin
                     if (req.key != 0) begin
                        if (status.full) begin
                           cmd.emit_status = 1'b1;
                           cmd.status_kind = KIND_FULL;
                        end else begin
                           cmd.load = 1'b1;
                           state_in = ST_INS_RD;
                        end
                     end
                  end
                  MODE_ASCEND, MODE_DESCEND: begin
                     if (status.count_zero) begin
                        cmd.emit_status = 1'b1;
                        cmd.status_kind = KIND_EMPTY;
                     end else begin
                        cmd.load = 1'b1;
                        state_in = ST_LST_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_INS_RD: begin
            if (status.ptr_zero) begin
               cmd.place = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.rd = 1'b1;
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            if (status.gt) begin
               cmd.shift = 1'b1;
               state_in = ST_INS_RD;
            end else begin
               cmd.place = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_LST_RD: begin
            cmd.rd = 1'b1;
            state_in = ST_LST_EMIT;
         end
         ST_LST_EMIT: begin
            cmd.emit_key = 1'b1;
            if (status.list_done) begin
               state_in = ST_IDLE;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_LST_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
endmodule

// ===== hdl/sorted_key_store_listing.sv =====
`timescale 1ns / 1ps
// insert: each entry moved passes through a read state and a compare state, then the key is placed
// listing: each key takes one memory read and one emit, and the emitted word is registered
// status words (full, empty) come in the cycle after start with no busy time
// each step waits on the single read port of the key memory
// synchronous reset empties the store and returns the controller to idle
module sorted_key_store_listing #(
   parameter int CAPACITY = sks_pkg::DEF_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  sks_pkg::req_type req_word,
   output logic             busy,
   output logic             rsp_valid,
   output sks_pkg::rsp_type rsp_word
);
   import sks_pkg::*;

   cmd_type    cmd;
   status_type status;

   sks_control u_control (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req    (req_word),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   sks_datapath #(.CAPACITY(CAPACITY)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_word)
   );
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import sks_pkg::*;

   localparam int CAP = DEF_CAPACITY;
   localparam int LIMIT = 2000000;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic clock;
   logic reset;
   logic start;
   req_type req;
   logic busy;
   logic rsp_valid;
   rsp_type rsp;

   sorted_key_store_listing u_dut (
      .clock(clock), .reset(reset), .start(start), .req_word(req),
      .busy(busy), .rsp_valid(rsp_valid), .rsp_word(rsp)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // pending commands and their pre-drawn gaps
   req_type cmd_queue[$];
   int gap_queue[$];
   // sorted copy of the stored keys and words still to come back
   logic signed [31:0] sorted_keys[$];
   rsp_type listing_words[$];

   int errors = 0;
   int cycles = 0;
   int sent = 0;
   int words_seen = 0;
   int inserts_sent = 0;
   int listings_sent = 0;
   int full_seen = 0;
   bit drain_hold = 0;
   int wait_cnt = 0;

   function automatic void predict_command(req_type c);
      rsp_type w;
      int pos;
      int n;
      n = sorted_keys.size();
      if (c.mode == MODE_INSERT) begin
         if (c.key == 0) return;
         if (n >= CAP) begin
            w.key_out = '0; w.kind = KIND_FULL; w.last = 1'b1;
            listing_words.push_back(w);
            return;
         end
         pos = n;
         while (pos > 0 && sorted_keys[pos-1] > c.key) pos--;
         sorted_keys.insert(pos, c.key);
      end else if (c.mode == MODE_ASCEND || c.mode == MODE_DESCEND) begin
         if (n == 0) begin
            w.key_out = '0; w.kind = KIND_EMPTY; w.last = 1'b1;
            listing_words.push_back(w);
            return;
         end
         for (int i = 0; i < n; i++) begin
            w.key_out = (c.mode == MODE_ASCEND) ? sorted_keys[i] : sorted_keys[n-1-i];
            w.kind = KIND_KEY;
            w.last = (i == n - 1);
            listing_words.push_back(w);
         end
      end
   endfunction

   function automatic void add_cmd(logic [1:0] m, logic signed [31:0] k, int g);
      req_type c;
      c.mode = m;
      c.key = k;
      cmd_queue.push_back(c);
      gap_queue.push_back(g);
   endfunction

   function automatic logic signed [31:0] rand_key();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff - $urandom_range(0, 3);
         1: return 32'sh80000000 + $urandom_range(0, 3);
         2: return $urandom_range(0, 20) - 10;
         default: return $urandom;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         start <= 1'b0;
         req <= '0;
         wait_cnt <= 0;
      end else if (start && !busy) begin
         predict_command(req);
         sent <= sent + 1;
         if (req.mode == MODE_INSERT) inserts_sent <= inserts_sent + 1;
         else if (req.mode != MODE_UNUSED) listings_sent <= listings_sent + 1;
         if (cmd_queue.size() > 0 && gap_queue[0] == 0 && !(drain_hold)) begin
            req <= cmd_queue.pop_front();
            void'(gap_queue.pop_front());
         end else begin
            start <= 1'b0;
            wait_cnt <= 0;
         end
      end else if (!start) begin
         if (cmd_queue.size() > 0 && !(drain_hold && listing_words.size() > 0)) begin
            if (wait_cnt >= gap_queue[0]) begin
               start <= 1'b1;
               req <= cmd_queue.pop_front();
               void'(gap_queue.pop_front());
            end else begin
               wait_cnt <= wait_cnt + 1;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      int bad;
      bad = 0;
      if (!reset && rsp_valid) begin
         words_seen <= words_seen + 1;
         if (rsp.kind == KIND_FULL) full_seen <= full_seen + 1;
         if (listing_words.size() == 0) begin
            $display("%0t: unexpected word key_out=%0d kind=%0d last=%0d",
               $time, rsp.key_out, rsp.kind, rsp.last);
            bad = bad + 1;
         end else begin
            e = listing_words.pop_front();
            if (e.key_out !== rsp.key_out) begin
               $display("%0t: key_out expected %0d actual %0d", $time, e.key_out, rsp.key_out);
               bad = bad + 1;
            end
            if (e.kind !== rsp.kind) begin
               $display("%0t: kind expected %0d actual %0d", $time, e.kind, rsp.kind);
               bad = bad + 1;
            end
            if (e.last !== rsp.last) begin
               $display("%0t: last expected %0d actual %0d", $time, e.last, rsp.last);
               bad = bad + 1;
            end
         end
      end
      errors <= errors + bad;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int r;
      reset = 1'b1;
      // directed: empty listings, zero key, extremes, unused mode
      add_cmd(MODE_ASCEND, 32'sd5, 0);
      add_cmd(MODE_DESCEND, 32'sd0, 3);
      add_cmd(MODE_INSERT, 32'sd0, 0);
      add_cmd(MODE_INSERT, 32'sh7fffffff, 0);
      add_cmd(MODE_INSERT, 32'sh80000000, 1);
      add_cmd(MODE_INSERT, -32'sd1, 0);
      add_cmd(MODE_INSERT, 32'sd1, 2);
      add_cmd(MODE_INSERT, 32'sd1, 0);
      add_cmd(MODE_UNUSED, 32'shffffffff, 0);
      add_cmd(MODE_ASCEND, 32'shffffffff, 0);
      add_cmd(MODE_DESCEND, 32'sh55555555, 0);
      add_cmd(MODE_INSERT, 32'shaaaaaaaa, 5);
      add_cmd(MODE_INSERT, 32'sh55555555, 0);
      add_cmd(MODE_ASCEND, 32'sd0, 0);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (cmd_queue.size() != 0 || start) @(negedge clock);
      // fill to capacity with inserts, many back to back, then overflow
      drain_hold = 1;
      while (listing_words.size() != 0) @(negedge clock);
      drain_hold = 0;
      for (int i = 0; i < CAP; i++) add_cmd(MODE_INSERT, rand_key() | 1, (i % 8 == 0) ? 0 : $urandom_range(0, 15) % 3);
      add_cmd(MODE_INSERT, 32'sd0, 0);
      add_cmd(MODE_INSERT, 32'sd7, 0);
      add_cmd(MODE_INSERT, 32'sh80000000, $urandom_range(0, 15));
      add_cmd(MODE_DESCEND, 32'sd0, 0);
      add_cmd(MODE_ASCEND, 32'sd0, $urandom_range(0, 15));
      while (cmd_queue.size() != 0 || start) @(negedge clock);
      while (listing_words.size() != 0) @(negedge clock);
      // reset is not reapplied, so random phase continues on a full store
      for (int i = 0; i < 36; i++) begin
         r = $urandom_range(0, 9);
         if (r < 6) add_cmd(MODE_INSERT, rand_key(), $urandom_range(0, 15));
         else if (r < 8) add_cmd(MODE_ASCEND, $urandom, $urandom_range(0, 15));
         else if (r < 9) add_cmd(MODE_DESCEND, $urandom, $urandom_range(0, 15));
         else add_cmd(MODE_UNUSED, $urandom, $urandom_range(0, 15));
         if (i % 20 == 19) add_cmd(MODE_ASCEND, 0, 0);
      end
      while (cmd_queue.size() != 0 || start) @(negedge clock);
      while (listing_words.size() != 0) @(negedge clock);
      repeat (300) @(posedge clock);
      $display("sent %0d commands (%0d inserts, %0d listings), checked %0d words",
         sent, inserts_sent, listings_sent, words_seen);
      $display("full rejections seen %0d, final store size %0d", full_seen, sorted_keys.size());
      if (errors == 0 && listing_words.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/sks_pkg.sv
hdl/sks_datapath.sv
hdl/sks_control.sv
hdl/sorted_key_store_listing.sv
tb/testbench.sv
